// ===== design/ldr_pkg.sv =====
// ----------------------------------------------------------------------------
// ldr_pkg
// Shared constants for the directional Laplacian ratio unit: field widths,
// register indexes and the fixed-point scale used for a zero vertical sum.
// ----------------------------------------------------------------------------
package ldr_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_PIXEL_BITS = 10;

    localparam int CFG_BITS       = 8;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_HEIGHT = 1'b1;
    localparam logic [CFG_BITS-1:0]       RESET_BLOCK_SIZE = 8'd128;

    localparam int SUM_BITS   = 25;
    localparam int FRAC_BITS  = 16;
    localparam int RATIO_BITS = 56;
    localparam int DIV_BITS   = SUM_BITS + FRAC_BITS;

    // 1 / 0.0001
    localparam int SCALE_BITS = 14;
    localparam logic [SCALE_BITS-1:0] ZERO_SCALE = 14'd10000;

endpackage

// ===== design/laplacian_direction_ratio_unit.sv =====
// ----------------------------------------------------------------------------
// laplacian_direction_ratio_unit
// Per-block sums of absolute vertical and horizontal second differences and
// their ratio in unsigned Q16.
// ----------------------------------------------------------------------------
// Pixels of a block enter in raster order, one beat each. For each pixel
// the two stored rows for its column are first read from the row store;
// then both second differences are formed and the sums updated. The last
// pixel of a block adds the end-of-block division: a 41-bit quotient from
// one radix-2 restoring divider (a single 26-bit compare and subtract),
// skipped entirely when the vertical sum is zero, followed by a load of the
// result register. A waiting result does not hold up the next block's
// pixels; only a second result finishing before the first is taken stalls.
// The row store has no clearing pass and needs none within a fixed-size block.
// ----------------------------------------------------------------------------
module laplacian_direction_ratio_unit
    import ldr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [PIXEL_BITS-1:0]     s_pixel,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [RATIO_BITS-1:0]     m_ratio_q16,
    output logic [SUM_BITS-1:0]       m_vertical_sum,
    output logic [SUM_BITS-1:0]       m_horizontal_sum,
    output logic                      m_vertical_was_zero
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS  = CFG_BITS;
    localparam int CMP_BITS  = ((COL_BITS > CFG_BITS) ? COL_BITS : CFG_BITS) + 2;
    localparam int DIFF_BITS = PIXEL_BITS + 1;
    localparam int CNT_BITS  = $clog2(DIV_BITS);
    localparam int PROD_BITS = SUM_BITS + SCALE_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [CFG_BITS-1:0]         width_reg, height_reg;
    logic [COL_BITS-1:0]         col_reg;
    logic [ROW_BITS-1:0]         row_reg;
    logic [PIXEL_BITS-1:0]       pix_reg;
    logic [PIXEL_BITS-1:0]       left0_reg, left1_reg;
    logic [SUM_BITS-1:0]         vacc_reg, hacc_reg;
    logic [2*PIXEL_BITS-1:0]     rd_reg;

    // row store: upper half two rows up, lower half one row up
    logic [2*PIXEL_BITS-1:0]     row_mem [MAX_WIDTH];

    logic [SUM_BITS-1:0]         div_vs_reg, div_hs_reg, rem_reg;
    logic [DIV_BITS-1:0]         quo_reg;
    logic [CNT_BITS-1:0]         cnt_reg;

    logic                        m_valid_reg;
    logic [RATIO_BITS-1:0]       m_ratio_reg;
    logic [SUM_BITS-1:0]         m_vsum_reg, m_hsum_reg;
    logic                        m_zero_reg;

    // effective block size
    logic [CMP_BITS-1:0] w_eff, h_eff, c_ext, r_ext;
    logic                vert_en, horz_en, row_end, last_row;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = CMP_BITS'(1);
        end else if (CMP_BITS'(width_reg) > CMP_BITS'(MAX_WIDTH)) begin
            w_eff = CMP_BITS'(MAX_WIDTH);
        end else begin
            w_eff = CMP_BITS'(width_reg);
        end
        h_eff = (height_reg == '0) ? CMP_BITS'(1) : CMP_BITS'(height_reg);
        c_ext = CMP_BITS'(col_reg);
        r_ext = CMP_BITS'(row_reg);
        vert_en  = (r_ext >= CMP_BITS'(2)) && (c_ext >= CMP_BITS'(1))
                   && (c_ext + CMP_BITS'(2) <= w_eff);
        horz_en  = (c_ext >= CMP_BITS'(2)) && (r_ext >= CMP_BITS'(1))
                   && (r_ext + CMP_BITS'(2) <= h_eff);
        row_end  = (c_ext + CMP_BITS'(1) >= w_eff);
        last_row = (r_ext + CMP_BITS'(1) >= h_eff);
    end

    // second differences and saturating sums
    logic [PIXEL_BITS-1:0] above, two_above;
    logic [DIFF_BITS-1:0]  v_s, v_d, v_diff, h_s, h_d, h_diff;
    logic [SUM_BITS:0]     v_add, h_add;
    logic [SUM_BITS-1:0]   v_new, h_new;

    always_comb begin
        above     = rd_reg[PIXEL_BITS-1:0];
        two_above = rd_reg[2*PIXEL_BITS-1:PIXEL_BITS];
        v_s    = {1'b0, two_above} + {1'b0, pix_reg};
        v_d    = {above, 1'b0};
        v_diff = (v_s >= v_d) ? (v_s - v_d) : (v_d - v_s);
        h_s    = {1'b0, left1_reg} + {1'b0, pix_reg};
        h_d    = {left0_reg, 1'b0};
        h_diff = (h_s >= h_d) ? (h_s - h_d) : (h_d - h_s);
        v_add  = {1'b0, vacc_reg} + (SUM_BITS+1)'(v_diff);
        h_add  = {1'b0, hacc_reg} + (SUM_BITS+1)'(h_diff);
        v_new  = vacc_reg;
        h_new  = hacc_reg;
        if (vert_en) begin
            v_new = v_add[SUM_BITS] ? {SUM_BITS{1'b1}} : v_add[SUM_BITS-1:0];
        end
        if (horz_en) begin
            h_new = h_add[SUM_BITS] ? {SUM_BITS{1'b1}} : h_add[SUM_BITS-1:0];
        end
    end

    // divider step
    logic [SUM_BITS:0]   rem_sh, rem_sub;
    logic                rem_ge;
    logic [SUM_BITS-1:0] rem_next;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[DIV_BITS-1]};
        rem_sub  = rem_sh - {1'b0, div_vs_reg};
        rem_ge   = (rem_sh >= {1'b0, div_vs_reg});
        rem_next = rem_ge ? rem_sub[SUM_BITS-1:0] : rem_sh[SUM_BITS-1:0];
    end

    logic [PROD_BITS-1:0] zero_prod;
    logic                 out_free;

    assign zero_prod = PROD_BITS'(div_hs_reg) * PROD_BITS'(ZERO_SCALE);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_CALC;
            end
            S_CALC: begin
                if (row_end && last_row) begin
                    state_next = (v_new == '0) ? S_DONE : S_DIV;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                if (cnt_reg == CNT_BITS'(DIV_BITS - 1)) state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            rd_reg <= row_mem[col_reg];
        end
        if (state_reg == S_CALC) begin
            row_mem[col_reg] <= {rd_reg[PIXEL_BITS-1:0], pix_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            width_reg   <= RESET_BLOCK_SIZE;
            height_reg  <= RESET_BLOCK_SIZE;
            col_reg     <= '0;
            row_reg     <= '0;
            left0_reg   <= '0;
            left1_reg   <= '0;
            vacc_reg    <= '0;
            hacc_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BLOCK_WIDTH:  width_reg  <= cfg_data;
                    REG_BLOCK_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) pix_reg <= s_pixel;
                end
                S_CALC: begin
                    if (!row_end) begin
                        col_reg   <= col_reg + COL_BITS'(1);
                        left1_reg <= left0_reg;
                        left0_reg <= pix_reg;
                        vacc_reg  <= v_new;
                        hacc_reg  <= h_new;
                    end else begin
                        col_reg   <= '0;
                        left0_reg <= '0;
                        left1_reg <= '0;
                        if (!last_row) begin
                            row_reg  <= row_reg + ROW_BITS'(1);
                            vacc_reg <= v_new;
                            hacc_reg <= h_new;
                        end else begin
                            row_reg    <= '0;
                            vacc_reg   <= '0;
                            hacc_reg   <= '0;
                            div_vs_reg <= v_new;
                            div_hs_reg <= h_new;
                            quo_reg    <= {h_new, {FRAC_BITS{1'b0}}};
                            rem_reg    <= '0;
                            cnt_reg    <= '0;
                        end
                    end
                end
                S_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[DIV_BITS-2:0], rem_ge};
                    cnt_reg <= cnt_reg + CNT_BITS'(1);
                end
                S_DONE: begin
                    if (out_free) begin
                        m_vsum_reg  <= div_vs_reg;
                        m_hsum_reg  <= div_hs_reg;
                        m_zero_reg  <= (div_vs_reg == '0);
                        if (div_vs_reg == '0) begin
                            m_ratio_reg <= RATIO_BITS'({zero_prod, {FRAC_BITS{1'b0}}});
                        end else begin
                            m_ratio_reg <= RATIO_BITS'(quo_reg);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_ready             = (state_reg == S_IDLE);
    assign m_valid             = m_valid_reg;
    assign m_ratio_q16         = m_ratio_reg;
    assign m_vertical_sum      = m_vsum_reg;
    assign m_horizontal_sum    = m_hsum_reg;
    assign m_vertical_was_zero = m_zero_reg;

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> div_vs_reg != '0)
        else $error("divider running on a zero vertical sum");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_BITS'(col_reg) < CMP_BITS'(MAX_WIDTH))
        else $error("column pointer beyond row store");

    a_accept_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_CALC)
        else $error("accepted beat not processed");

    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_vertical_was_zero |-> m_vertical_sum == '0)
        else $error("zero flag with non-zero vertical sum");

    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_vertical_was_zero |-> m_ratio_q16[RATIO_BITS-1:DIV_BITS] == '0)
        else $error("quotient wider than dividend");

endmodule

// ===== sim/tb_laplacian_direction_ratio_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_laplacian_direction_ratio_unit
// Streams pixel blocks of many sizes and textures through the unit and checks
// every ratio beat against a cycle-free prediction of the second-difference
// sums, including zero sizes, oversize widths, tall blocks, mid-block size
// changes and a zero vertical sum, under random back-pressure.
// ----------------------------------------------------------------------------
module tb_laplacian_direction_ratio_unit;
    import ldr_pkg::*;

    localparam int PIX_BITS = DEF_PIXEL_BITS;
    localparam int PIXEL_MAX = (1 << PIX_BITS) - 1;
    localparam int COL_BITS = $clog2(DEF_MAX_WIDTH);
    localparam int TONE_BITS = 8;
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_PIXELS = 150;
    localparam int RANDOM_RATIOS = 8;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [RATIO_BITS-1:0] ratio;
        logic [SUM_BITS-1:0]   vsum;
        logic [SUM_BITS-1:0]   hsum;
        logic                  vzero;
    } ratio_result_t;

    typedef enum int {
        TEX_RANDOM, TEX_SMOOTH, TEX_CHECKER, TEX_COLUMNS, TEX_ROWS, TEX_FLAT
    } texture_t;

    class ratio_tracker;
        logic [CFG_BITS-1:0] width_reg;
        logic [CFG_BITS-1:0] height_reg;
        logic [PIX_BITS-1:0] row_above [DEF_MAX_WIDTH];
        logic [PIX_BITS-1:0] row_two_above [DEF_MAX_WIDTH];
        logic [PIX_BITS-1:0] left_near, left_far;
        int unsigned         col, row;
        logic [SUM_BITS-1:0] vert_acc, horiz_acc;
        ratio_result_t       pending_ratios[$];
        int                  made;
        int                  errors;

        function new();
            width_reg = RESET_BLOCK_SIZE;
            height_reg = RESET_BLOCK_SIZE;
            foreach (row_above[i]) begin
                row_above[i] = '0;
                row_two_above[i] = '0;
            end
            made = 0;
            errors = 0;
            clear_block();
        endfunction

        function void clear_block();
            left_near = '0;
            left_far = '0;
            col = 0;
            row = 0;
            vert_acc = '0;
            horiz_acc = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
            if (idx == REG_BLOCK_WIDTH)
                width_reg = val;
            else if (idx == REG_BLOCK_HEIGHT)
                height_reg = val;
        endfunction

        function logic [PIX_BITS:0] second_diff(logic [PIX_BITS-1:0] a, b, mid);
            logic [PIX_BITS:0] s, d;
            s = {1'b0, a} + {1'b0, b};
            d = {mid, 1'b0};
            return (s >= d) ? s - d : d - s;
        endfunction

        function logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] acc, logic [PIX_BITS:0] v);
            logic [SUM_BITS:0] t;
            t = {1'b0, acc} + (SUM_BITS+1)'(v);
            return (t > {1'b0, SUM_MAX}) ? SUM_MAX : t[SUM_BITS-1:0];
        endfunction

        function void take_pixel(logic [PIX_BITS-1:0] p);
            int unsigned         w, h, c, r;
            logic [COL_BITS-1:0] ci;
            logic [63:0]         hs, vs, quot;
            ratio_result_t       res;
            w = 32'(width_reg);
            h = 32'(height_reg);
            c = col;
            r = row;
            if (w == 0) w = 1;
            if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
            if (h == 0) h = 1;
            if (c >= DEF_MAX_WIDTH) c = DEF_MAX_WIDTH - 1;
            ci = COL_BITS'(c);

            // vertical term is centred one row up, horizontal one column left
            if (r >= 2 && c >= 1 && c + 2 <= w)
                vert_acc = sat_add(vert_acc, second_diff(row_two_above[ci], p, row_above[ci]));
            if (c >= 2 && r >= 1 && r + 2 <= h)
                horiz_acc = sat_add(horiz_acc, second_diff(left_far, p, left_near));

            row_two_above[ci] = row_above[ci];
            row_above[ci] = p;
            left_far = left_near;
            left_near = p;

            if (c + 1 < w) begin
                col = c + 1;
                return;
            end
            col = 0;
            left_near = '0;
            left_far = '0;
            if (r + 1 < h) begin
                row = r + 1;
                return;
            end

            hs = 64'(horiz_acc);
            vs = 64'(vert_acc);
            res.vzero = (vs == 0);
            // a zero vertical sum stands for 0.0001
            quot = res.vzero ? (hs * ZERO_SCALE) << FRAC_BITS : (hs << FRAC_BITS) / vs;
            res.ratio = quot[RATIO_BITS-1:0];
            res.vsum = vert_acc;
            res.hsum = horiz_acc;
            pending_ratios = {pending_ratios, res};
            made++;
            clear_block();
        endfunction

        function int pending_count();
            return pending_ratios.size();
        endfunction

        function void mismatch(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
        endfunction

        function void check_result(logic [RATIO_BITS-1:0] ratio, logic [SUM_BITS-1:0] vsum,
                                   logic [SUM_BITS-1:0] hsum, logic vzero);
            ratio_result_t want;
            if (pending_ratios.size() == 0) begin
                mismatch("unexpected beat, ratio", '0, 64'(ratio));
                return;
            end
            want = pending_ratios.pop_front();
            if (ratio !== want.ratio) mismatch("ratio_q16", 64'(want.ratio), 64'(ratio));
            if (vsum !== want.vsum) mismatch("vertical_sum", 64'(want.vsum), 64'(vsum));
            if (hsum !== want.hsum) mismatch("horizontal_sum", 64'(want.hsum), 64'(hsum));
            if (vzero !== want.vzero)
                mismatch("vertical_was_zero", 64'(want.vzero), 64'(vzero));
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]       cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [PIX_BITS-1:0]       s_pixel;
    logic                      m_valid;
    logic                      m_ready;
    logic [RATIO_BITS-1:0]     m_ratio_q16;
    logic [SUM_BITS-1:0]       m_vertical_sum;
    logic [SUM_BITS-1:0]       m_horizontal_sum;
    logic                      m_vertical_was_zero;

    ratio_tracker        tracker = new();
    logic [PIX_BITS-1:0] tone [256];
    bit                  no_idle = 1'b0;
    bit                  hold_request = 1'b0;
    int                  pixels_sent = 0;
    int unsigned         cycle_count = 0;

    laplacian_direction_ratio_unit DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_pixel             (s_pixel),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_ratio_q16         (m_ratio_q16),
        .m_vertical_sum      (m_vertical_sum),
        .m_horizontal_sum    (m_horizontal_sum),
        .m_vertical_was_zero (m_vertical_was_zero)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function int pick_gap();
        int sel;
        if (no_idle)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            return 0;
        if (sel < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function logic [PIX_BITS-1:0] next_pixel(texture_t tex);
        int unsigned lvl;
        case (tex)
            TEX_RANDOM: return PIX_BITS'($urandom_range(0, PIXEL_MAX));
            TEX_SMOOTH: begin
                lvl = tone[0] + $urandom_range(0, 15);
                return PIX_BITS'((lvl > PIXEL_MAX) ? PIXEL_MAX : lvl);
            end
            TEX_CHECKER: return PIX_BITS'(((tracker.col + tracker.row) % 2) ? PIXEL_MAX : 0);
            TEX_COLUMNS: return tone[TONE_BITS'(tracker.col)];
            TEX_ROWS:    return tone[TONE_BITS'(tracker.row)];
            default:     return tone[0];
        endcase
    endfunction

    function texture_t random_texture();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 8)  return TEX_RANDOM;
        if (sel < 12) return TEX_SMOOTH;
        if (sel < 15) return TEX_COLUMNS;
        if (sel < 17) return TEX_ROWS;
        if (sel < 18) return TEX_CHECKER;
        return TEX_FLAT;
    endfunction

    task send_pixel(input logic [PIX_BITS-1:0] p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= p;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        tracker.take_pixel(p);
        pixels_sent++;
    endtask

    // keeps sending until the current block has produced its beat
    task finish_block(input texture_t tex);
        int start;
        start = tracker.made;
        foreach (tone[i]) tone[i] = PIX_BITS'($urandom_range(0, PIXEL_MAX));
        while (tracker.made == start) send_pixel(next_pixel(tex));
    endtask

    task write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        tracker.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // waits until every expected beat has been taken, then idles with s_valid low
    task settle();
        s_valid <= 1'b0;
        while (tracker.pending_count() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task run_phase(input int w, input int h, input int blocks, input texture_t tex);
        write_reg(REG_BLOCK_WIDTH, CFG_BITS'(w));
        write_reg(REG_BLOCK_HEIGHT, CFG_BITS'(h));
        repeat (blocks) finish_block(tex);
        settle();
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (m_valid && m_ready)
                tracker.check_result(m_ratio_q16, m_vertical_sum, m_horizontal_sum,
                                     m_vertical_was_zero);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    initial begin
        int w, h, base_made, base_px, weff, heff;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_pixel <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // full-scale checkerboard: both differences at their maximum
        run_phase(3, 3, 1, TEX_CHECKER);
        // blocks with no interior, zero sizes acting as one
        run_phase(1, 1, 2, TEX_RANDOM);
        run_phase(0, 0, 1, TEX_RANDOM);
        run_phase(2, 2, 1, TEX_RANDOM);
        // zero vertical sum takes the scaled path; zero horizontal gives ratio 0
        run_phase(4, 3, 1, TEX_COLUMNS);
        run_phase(5, 4, 1, TEX_ROWS);
        run_phase(3, 3, 1, TEX_FLAT);

        // size change inside a block: shorter first, then narrower mid-row
        write_reg(REG_BLOCK_WIDTH, CFG_BITS'(6));
        write_reg(REG_BLOCK_HEIGHT, CFG_BITS'(6));
        repeat (18) send_pixel(PIX_BITS'($urandom_range(0, PIXEL_MAX)));
        settle();
        write_reg(REG_BLOCK_HEIGHT, CFG_BITS'(4));
        finish_block(TEX_RANDOM);
        settle();
        write_reg(REG_BLOCK_HEIGHT, CFG_BITS'(5));
        repeat (15) send_pixel(PIX_BITS'($urandom_range(0, PIXEL_MAX)));
        settle();
        write_reg(REG_BLOCK_WIDTH, CFG_BITS'(3));
        finish_block(TEX_RANDOM);
        settle();

        // receiver holds off long enough for the input to back up
        hold_request = 1'b1;
        run_phase(4, 4, 6, TEX_RANDOM);

        base_made = tracker.made;
        base_px = pixels_sent;
        while (pixels_sent - base_px < RANDOM_PIXELS || tracker.made - base_made < RANDOM_RATIOS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                7:       w = 0;
                8, 9:    w = $urandom_range(13, 255);
                default: w = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 9))
                8:       h = 0;
                9:       h = $urandom_range(13, 255);
                default: h = $urandom_range(1, 12);
            endcase
            weff = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
            heff = (h == 0) ? 1 : h;
            if (weff * heff > 200)
                h = 200 / weff;
            run_phase(w, h, $urandom_range(1, 4), random_texture());
        end

        // the few large blocks: oversize width and a tall block
        no_idle = 1'b0;
        run_phase(255, 3, 1, TEX_RANDOM);
        run_phase(1, 255, 1, TEX_RANDOM);

        settle();
        if (tracker.errors == 0 && tracker.pending_count() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
